FILE: hw/rtl/apsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsg_pkg
// Shared widths, constants and helpers for the attitude pointer slew core.
// ----------------------------------------------------------------------------
package apsg_pkg;

    localparam int PTR_W   = 20;   // pointer and target angles, millidegrees
    localparam int ACC_W   = 22;   // working width for unwrapped angles and errors
    localparam int CAL_W   = 5;
    localparam int CALT_W  = 6;
    localparam int TIME_W  = 32;
    localparam int EXTRA_W = 7;
    localparam int RUN_W   = 9;
    localparam int DRIFT_W = 8;

    localparam int IN_W  = 80;
    localparam int OUT_W = 48;

    localparam logic signed [ACC_W-1:0] PTR_LIMIT    = ACC_W'(400000);
    localparam logic signed [ACC_W-1:0] UNWRAP_LIMIT = ACC_W'(300000);
    localparam logic signed [ACC_W-1:0] FULL_TURN    = ACC_W'(360000);

    localparam logic signed [ACC_W-1:0] PITCH_DRIFT_LIMIT = ACC_W'(90000);
    localparam logic signed [ACC_W-1:0] BANK_DRIFT_LIMIT  = ACC_W'(180000);
    localparam logic signed [ACC_W-1:0] PITCH_DRIFT_STEP  = ACC_W'(30);
    localparam logic signed [ACC_W-1:0] BANK_DRIFT_STEP   = ACC_W'(300);

    localparam logic [RUN_W-1:0]   BASE_RUNDOWN     = RUN_W'(300);
    localparam logic [DRIFT_W-1:0] DRIFT_TICKS_LAST = DRIFT_W'(200);
    localparam logic [DRIFT_W-1:0] DRIFT_HOLD       = DRIFT_W'(201);

    localparam logic signed [CALT_W-1:0] CAL_LIMIT = CALT_W'(10);

    // Clamp a working-width angle to the pointer range.
    function automatic logic signed [PTR_W-1:0] sat_ptr(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        begin
            if (v > PTR_LIMIT)
            begin
                c = PTR_LIMIT;
            end
            else if (v < -PTR_LIMIT)
            begin
                c = -PTR_LIMIT;
            end
            else
            begin
                c = v;
            end
            return c[PTR_W-1:0];
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_ptr(input logic signed [PTR_W-1:0] v);
        return {{(ACC_W-PTR_W){v[PTR_W-1]}}, v};
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/apsg_slew.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsg_slew
// One tick of pointer slew: error-sized step toward the target, or snap.
// ----------------------------------------------------------------------------
module apsg_slew
    import apsg_pkg::*;
(
    input  wire logic signed [ACC_W-1:0] cur,
    input  wire logic signed [ACC_W-1:0] target,
    output logic signed [PTR_W-1:0]      nxt
);

    logic signed [ACC_W-1:0] diff;
    logic signed [ACC_W-1:0] err;
    logic signed [ACC_W-1:0] step;
    logic                    snap;

    assign diff = target - cur;
    assign err  = diff[ACC_W-1] ? -diff : diff;

    always_comb
    begin
        snap = 1'b0;
        if (err > ACC_W'(80000))
        begin
            step = ACC_W'(20000);
        end
        else if (err > ACC_W'(40000))
        begin
            step = ACC_W'(10000);
        end
        else if (err > ACC_W'(20000))
        begin
            step = ACC_W'(5000);
        end
        else if (err > ACC_W'(10000))
        begin
            step = ACC_W'(2500);
        end
        else if (err > ACC_W'(5000))
        begin
            step = ACC_W'(1250);
        end
        else if (err > ACC_W'(625))
        begin
            step = ACC_W'(625);
        end
        else
        begin
            step = '0;
            snap = 1'b1;
        end
    end

    always_comb
    begin
        if (snap)
        begin
            nxt = sat_ptr(target);
        end
        else if (cur < target)
        begin
            nxt = sat_ptr(cur + step);
        end
        else
        begin
            nxt = sat_ptr(cur - step);
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/attitude_pointer_slew_with_gyro_failure_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// attitude_pointer_slew_with_gyro_failure_core
// Attitude indicator pitch/bank pointer slew with gyro run-down failure.
// ----------------------------------------------------------------------------
// Path: input beat to result beat through the input register and the result
// register; the result register holds while the output is stalled.
// Throughput: one beat per cycle while the output is not stalled; the pointer
// state updates through the slew logic, so each tick sees the previous tick's state.
// Reset: rst_n low clears pointers, calibration, drift count, power time and
// cal_target to zero, run-down time to 300 s, and empties both registers.
module attitude_pointer_slew_with_gyro_failure_core
    import apsg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // tdata: target_pitch[19:0], target_bank[39:20], power_on[40],
    //        now_seconds[72:41], spin_extra_seconds[79:73]
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    // tdata: pitch_pointer[19:0], bank_pointer[39:20], cal_offset[44:40],
    //        gyro_failed[45], zero[47:46]
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CALT_W-1:0] cfg_data
);

    // input register
    logic                      in_valid_reg;
    logic signed [PTR_W-1:0]   tp_reg;
    logic signed [PTR_W-1:0]   tb_reg;
    logic                      power_reg;
    logic [TIME_W-1:0]         now_reg;
    logic [EXTRA_W-1:0]        extra_reg;

    // block state
    logic signed [PTR_W-1:0]   pitch_reg, pitch_next;
    logic signed [PTR_W-1:0]   bank_reg, bank_next;
    logic signed [CAL_W-1:0]   cal_reg, cal_next;
    logic [DRIFT_W-1:0]        drift_reg, drift_next;
    logic [RUN_W-1:0]          rundown_reg, rundown_next;
    logic [TIME_W-1:0]         seen_reg, seen_next;
    logic signed [CALT_W-1:0]  cal_target_reg;

    // result register
    logic                      out_valid_reg;
    logic [OUT_W-1:0]          out_data_reg;

    logic                      advance;
    logic [TIME_W-1:0]         elapsed;
    logic                      failed;
    logic signed [ACC_W-1:0]   pitch_ext;
    logic signed [ACC_W-1:0]   bank_ext;
    logic signed [ACC_W-1:0]   tp_ext;
    logic signed [ACC_W-1:0]   tb_ext;
    logic signed [ACC_W-1:0]   bank_diff;
    logic signed [ACC_W-1:0]   bank_err;
    logic signed [ACC_W-1:0]   bank_unwrap;
    logic signed [PTR_W-1:0]   pitch_slew;
    logic signed [PTR_W-1:0]   bank_slew;
    logic signed [CALT_W-1:0]  cal_ext;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign pitch_ext = ext_ptr(pitch_reg);
    assign bank_ext  = ext_ptr(bank_reg);
    assign tp_ext    = ext_ptr(tp_reg);
    assign tb_ext    = ext_ptr(tb_reg);
    assign cal_ext   = {cal_reg[CAL_W-1], cal_reg};

    // A clock that runs backward wraps to a long outage.
    assign elapsed = power_reg ? '0 : now_reg - seen_reg;
    assign failed  = elapsed >= {{(TIME_W-RUN_W){1'b0}}, rundown_reg};

    // Unwrap a bank error beyond 300 degrees by a full turn before stepping.
    assign bank_diff = tb_ext - bank_ext;
    assign bank_err  = bank_diff[ACC_W-1] ? -bank_diff : bank_diff;

    always_comb
    begin
        if (bank_err > UNWRAP_LIMIT)
        begin
            bank_unwrap = (bank_ext < tb_ext) ? bank_ext + FULL_TURN : bank_ext - FULL_TURN;
        end
        else
        begin
            bank_unwrap = bank_ext;
        end
    end

    apsg_slew u_pitch_slew
    (
        .cur    (pitch_ext),
        .target (tp_ext),
        .nxt    (pitch_slew)
    );

    apsg_slew u_bank_slew
    (
        .cur    (bank_unwrap),
        .target (tb_ext),
        .nxt    (bank_slew)
    );

    always_comb
    begin
        pitch_next   = pitch_reg;
        bank_next    = bank_reg;
        cal_next     = cal_reg;
        drift_next   = drift_reg;
        rundown_next = rundown_reg;
        seen_next    = seen_reg;

        if (power_reg)
        begin
            seen_next    = now_reg;
            rundown_next = BASE_RUNDOWN + {{(RUN_W-EXTRA_W){1'b0}}, extra_reg};
            drift_next   = '0;
        end

        if (failed)
        begin
            if (drift_reg <= DRIFT_TICKS_LAST)
            begin
                drift_next = drift_reg + DRIFT_W'(1);
                if (pitch_ext < PITCH_DRIFT_LIMIT)
                begin
                    pitch_next = sat_ptr(pitch_ext + PITCH_DRIFT_STEP);
                end
                if (bank_ext < BANK_DRIFT_LIMIT)
                begin
                    bank_next = sat_ptr(bank_ext + BANK_DRIFT_STEP);
                end
            end
            else
            begin
                drift_next = DRIFT_HOLD;
            end
        end
        else
        begin
            pitch_next = pitch_slew;
            bank_next  = bank_slew;
            if (cal_ext > cal_target_reg && cal_ext > -CAL_LIMIT)
            begin
                cal_next = cal_reg - CAL_W'(1);
            end
            else if (cal_ext < cal_target_reg && cal_ext < CAL_LIMIT)
            begin
                cal_next = cal_reg + CAL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pitch_reg      <= '0;
            bank_reg       <= '0;
            cal_reg        <= '0;
            drift_reg      <= '0;
            rundown_reg    <= BASE_RUNDOWN;
            seen_reg       <= '0;
            cal_target_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pitch_reg     <= pitch_next;
                bank_reg      <= bank_next;
                cal_reg       <= cal_next;
                drift_reg     <= drift_next;
                rundown_reg   <= rundown_next;
                seen_reg      <= seen_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                cal_target_reg <= cfg_data;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            tp_reg    <= s_axis_tdata[19:0];
            tb_reg    <= s_axis_tdata[39:20];
            power_reg <= s_axis_tdata[40];
            now_reg   <= s_axis_tdata[72:41];
            extra_reg <= s_axis_tdata[79:73];
        end
        if (advance)
        begin
            out_data_reg <= {2'b00, failed, cal_next, bank_next, pitch_next};
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/apsg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apsg_checker
// Port-level checks on the attitude pointer slew core, bound to the top level.
// ----------------------------------------------------------------------------
module apsg_checker
    import apsg_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_W-1:0]  m_axis_tdata,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic [CALT_W-1:0] cfg_data
);

    logic signed [PTR_W-1:0] out_pitch;
    logic signed [PTR_W-1:0] out_bank;
    logic signed [CAL_W-1:0] out_cal;

    assign out_pitch = m_axis_tdata[19:0];
    assign out_bank  = m_axis_tdata[39:20];
    assign out_cal   = m_axis_tdata[44:40];

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // no result beat shows during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // pointers saturate and the calibration offset stays clamped
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_pitch <= 20'sd400000) && (out_pitch >= -20'sd400000)
            && (out_bank <= 20'sd400000) && (out_bank >= -20'sd400000)
            && (out_cal <= 5'sd10) && (out_cal >= -5'sd10)
            && (m_axis_tdata[47:46] == 2'b00))
        else $error("result field out of range");

    // the input is blocked only while a result beat is stalled at the output
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without an output stall");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready || $stable(cfg_data))
        else $error("configuration write not taken");

endmodule

bind attitude_pointer_slew_with_gyro_failure_core apsg_checker u_apsg_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
);
`default_nettype wire
